>>> rtl/lsp_pkg.sv
// Shared types, constants and codes of the line sensor position estimator.
`default_nettype none
package lsp_pkg;

    localparam int SENSORS_DEF     = 8;
    localparam int ADC_BITS_DEF    = 10;
    localparam int BURST_READS_DEF = 10;

    localparam int INPUT_LANES = 8;
    localparam int KIND_W      = 2;
    localparam int SAMPLE_W    = 10;
    localparam int POS_W       = 13;
    localparam int READ_W      = 16;
    localparam int SUM_W       = 16;
    localparam int VAL_W       = 10;
    localparam int SC_W        = 4;
    localparam int SPS_W       = 7;
    localparam int MAXV_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    localparam int SCALE       = 1000;
    localparam int LINE_LEVEL  = 200;
    localparam int NOISE_LEVEL = 50;
    localparam int MAX_SAMPLES = 64;

    localparam int AVG_STEPS   = 16;
    localparam int MAP_STEPS   = 10;
    localparam int LANE_DIVD_W = 26;
    localparam int LANE_Q_W    = 16;
    localparam int STEP_W      = 5;

    localparam int SENSOR_COUNT_RST = 8;
    localparam int SPS_RST          = 4;
    localparam int MAX_VALUE_RST    = 1023;
    localparam int CAL_EN_RST       = 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LINE  = 2'd0,
        KIND_CAL   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_COUNT = 2'd0,
        CFG_SAMPLES      = 2'd1,
        CFG_MAX_VALUE    = 2'd2,
        CFG_CAL_ENABLE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              accum;
        logic              avg_start;
        logic              rd_load;
        logic              map_start;
        logic              burst_update;
        logic              burst_first;
        logic              burst_end;
        logic              cal_clear;
        logic [SPS_W-1:0]  samples;
        logic [MAXV_W-1:0] max_value;
    } t_lane_ctl;

endpackage
`default_nettype wire

>>> rtl/lsp_in_if.sv
// Scan input channel: kind and raw samples of eight sensors.
`default_nettype none
interface lsp_in_if import lsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;

    modport source (output valid, kind, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, sample_7, input ready);
    modport sink   (input valid, kind, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, sample_7, output ready);
endinterface
`default_nettype wire

>>> rtl/lsp_out_if.sv
// Result channel: line position and status flags.
`default_nettype none
interface lsp_out_if import lsp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic             line_seen;
    logic             not_calibrated;

    modport source (output valid, position, line_seen, not_calibrated, input ready);
    modport sink   (input valid, position, line_seen, not_calibrated, output ready);
endinterface
`default_nettype wire

>>> rtl/lsp_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none
interface lsp_cfg_if import lsp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/line_sensor_position_estimator_unit.sv
// Top level of the line sensor position estimator.
// Each accepted scan is added into per-sensor sums; a scan that does not
// complete a reading leaves the unit idle, so the input stays ready. When
// samples_per_sensor scans are in, every lane rounds its sum with a
// shift-subtract divider. A calibration reading then updates the burst and
// calibration and returns to idle; a line reading before the first
// calibration reading gives a not-calibrated result. A line
// reading maps each lane with the same divider, the merge stage walks the
// active lanes one per cycle and divides out the position, and the result
// goes to the output register. A reset-calibration item clears the
// calibration and leaves the unit idle. The next item is taken while a
// result waits in the output register.
`default_nettype none
module line_sensor_position_estimator_unit import lsp_pkg::*; #(
    parameter int SENSORS     = SENSORS_DEF,
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int BURST_READS = BURST_READS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lsp_in_if.sink    i_in,
    lsp_out_if.source o_out,
    lsp_cfg_if.sink   i_cfg
);
    localparam int NW   = $clog2(SENSORS + 1);
    localparam int BC_W = $clog2(BURST_READS + 1);
    localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_AVG_START, S_AVG, S_CAL, S_MAP_START, S_MAP, S_MERGE, S_OUT
    } t_state;

    t_state            r_state;
    logic [SC_W-1:0]   r_sensor_count;
    logic [SPS_W-1:0]  r_samples;
    logic [MAXV_W-1:0] r_max_value;
    logic              r_cal_en;
    logic [SPS_W-1:0]  r_scan;
    logic [BC_W-1:0]   r_burst;
    logic              r_flag;
    t_kind             r_kind;
    logic [STEP_W-1:0] r_wait;
    logic [POS_W-1:0]  r_res_pos;
    logic              r_res_seen;
    logic              r_res_notcal;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_seen;
    logic              r_out_notcal;

    logic                w_accept;
    t_kind               w_kind;
    logic                w_take;
    logic [SPS_W-1:0]    w_ns;
    logic [SPS_W-1:0]    n_scan;
    logic [BC_W-1:0]     n_burst;
    logic [NW-1:0]       w_n;
    t_lane_ctl           w_ctl;
    logic                w_merge_start;
    logic                w_merge_done;
    logic [POS_W-1:0]    w_merge_pos;
    logic                w_merge_seen;
    logic [SAMPLE_W-1:0] w_fields [INPUT_LANES];
    logic [VAL_W-1:0]    w_values [SENSORS];

    assign w_fields[0] = i_in.sample_0;
    assign w_fields[1] = i_in.sample_1;
    assign w_fields[2] = i_in.sample_2;
    assign w_fields[3] = i_in.sample_3;
    assign w_fields[4] = i_in.sample_4;
    assign w_fields[5] = i_in.sample_5;
    assign w_fields[6] = i_in.sample_6;
    assign w_fields[7] = i_in.sample_7;

    always_comb begin
        if (r_sensor_count == '0) begin
            w_n = NW'(1);
        end else if (32'(r_sensor_count) > 32'(SENSORS)) begin
            w_n = NW'(SENSORS);
        end else begin
            w_n = NW'(r_sensor_count);
        end
        if (r_samples == '0) begin
            w_ns = SPS_W'(1);
        end else if (r_samples > SPS_W'(MAX_SAMPLES)) begin
            w_ns = SPS_W'(MAX_SAMPLES);
        end else begin
            w_ns = r_samples;
        end
        w_accept = i_in.valid && (r_state == S_IDLE);
        w_kind   = t_kind'(i_in.kind);
        w_take   = (w_kind == KIND_LINE) || (w_kind == KIND_CAL && r_cal_en);
        n_scan   = r_scan + SPS_W'(1);
        n_burst  = r_burst + BC_W'(1);

        w_ctl              = '0;
        w_ctl.samples      = w_ns;
        w_ctl.max_value    = r_max_value;
        w_ctl.accum        = w_accept && w_take;
        w_ctl.avg_start    = (r_state == S_AVG_START);
        w_ctl.rd_load      = (r_state == S_AVG) && (r_wait == '0);
        w_ctl.map_start    = (r_state == S_MAP_START);
        w_ctl.burst_update = (r_state == S_CAL);
        w_ctl.burst_first  = (r_burst == '0);
        w_ctl.burst_end    = 32'(n_burst) >= 32'(BURST_READS);
        w_ctl.cal_clear    = (w_accept && w_kind == KIND_CLEAR) ||
                             ((r_state == S_CAL) && r_burst == '0 && !r_flag);
        w_merge_start      = (r_state == S_MAP) && (r_wait == '0);
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    for (genvar g = 0; g < SENSORS; g++) begin : g_lane
        logic [SAMPLE_W-1:0] w_sample;
        if (g < INPUT_LANES) begin : g_field
            assign w_sample = w_fields[g] & ADC_MASK;
        end else begin : g_none
            assign w_sample = '0;
        end
        lsp_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_active (w_n > NW'(g)),
            .i_sample (w_sample),
            .o_value  (w_values[g])
        );
    end

    lsp_merge #(
        .SENSORS (SENSORS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_merge_start),
        .i_count    (w_n),
        .i_values   (w_values),
        .o_done     (w_merge_done),
        .o_position (w_merge_pos),
        .o_seen     (w_merge_seen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sensor_count <= SC_W'(SENSOR_COUNT_RST);
            r_samples      <= SPS_W'(SPS_RST);
            r_max_value    <= MAXV_W'(MAX_VALUE_RST);
            r_cal_en       <= 1'(CAL_EN_RST);
            r_scan         <= '0;
            r_burst        <= '0;
            r_flag         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_SENSOR_COUNT: r_sensor_count <= i_cfg.data[SC_W-1:0];
                    CFG_SAMPLES:      r_samples      <= i_cfg.data[SPS_W-1:0];
                    CFG_MAX_VALUE:    r_max_value    <= i_cfg.data[MAXV_W-1:0];
                    CFG_CAL_ENABLE:   r_cal_en       <= i_cfg.data[0];
                    default:          r_cal_en       <= r_cal_en;
                endcase
            end
            if (o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_take) begin
                        r_kind <= w_kind;
                        if (n_scan >= w_ns) begin
                            r_scan  <= '0;
                            r_state <= S_AVG_START;
                        end else begin
                            r_scan <= n_scan;
                        end
                    end
                end
                S_AVG_START: begin
                    r_wait  <= STEP_W'(AVG_STEPS);
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    if (r_wait == '0) begin
                        if (r_kind == KIND_CAL) begin
                            r_state <= S_CAL;
                        end else if (!r_flag) begin
                            r_res_pos    <= '0;
                            r_res_seen   <= 1'b0;
                            r_res_notcal <= 1'b1;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_MAP_START;
                        end
                    end else begin
                        r_wait <= r_wait - STEP_W'(1);
                    end
                end
                S_CAL: begin
                    r_flag  <= 1'b1;
                    r_burst <= w_ctl.burst_end ? '0 : n_burst;
                    r_state <= S_IDLE;
                end
                S_MAP_START: begin
                    r_wait  <= STEP_W'(MAP_STEPS);
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    if (r_wait == '0) begin
                        r_state <= S_MERGE;
                    end else begin
                        r_wait <= r_wait - STEP_W'(1);
                    end
                end
                S_MERGE: begin
                    if (w_merge_done) begin
                        r_res_pos    <= w_merge_pos;
                        r_res_seen   <= w_merge_seen;
                        r_res_notcal <= 1'b0;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_pos    <= r_res_pos;
                        r_out_seen   <= r_res_seen;
                        r_out_notcal <= r_res_notcal;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.position       = r_out_pos;
    assign o_out.line_seen      = r_out_seen;
    assign o_out.not_calibrated = r_out_notcal;
endmodule
`default_nettype wire

>>> rtl/lsp_div.sv
// Iterative shift-subtract divider, one quotient bit per cycle.
`default_nettype none
module lsp_div import lsp_pkg::*; #(
    parameter int DW = LANE_DIVD_W,
    parameter int VW = READ_W,
    parameter int QW = LANE_Q_W,
    parameter int SW = $clog2(QW + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    input  wire logic [SW-1:0] i_steps,
    output logic      [QW-1:0] o_quotient
);
    localparam int CW = (DW > VW + QW - 1) ? DW : VW + QW - 1;

    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_dsh;
    logic [QW-1:0] r_q;
    logic [SW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_rem <= CW'(i_dividend);
            r_dsh <= CW'(i_divisor) << (i_steps - SW'(1));
            r_q   <= '0;
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - SW'(1);
        end
    end

    assign o_quotient = r_q;
endmodule
`default_nettype wire

>>> rtl/lsp_lane.sv
// One sensor lane: scan accumulation, rounding, burst and calibration, mapping.
`default_nettype none
module lsp_lane import lsp_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_lane_ctl           i_ctl,
    input  wire logic                i_active,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic      [VAL_W-1:0]    o_value
);
    typedef enum logic [1:0] {MAP_ZERO, MAP_FULL, MAP_DIV} t_map;

    logic [SUM_W-1:0]       r_sum;
    logic [READ_W-1:0]      r_rd;
    logic [READ_W-1:0]      r_blo;
    logic [READ_W-1:0]      r_bhi;
    logic [READ_W-1:0]      r_chi;
    logic [READ_W-1:0]      r_clo;
    t_map                   r_map;

    logic [READ_W-1:0]      w_den;
    logic [READ_W-1:0]      w_diff;
    logic [READ_W-1:0]      w_eff_hi;
    logic [READ_W-1:0]      w_eff_lo;
    logic [READ_W-1:0]      n_blo;
    logic [READ_W-1:0]      n_bhi;
    logic                   w_div_start;
    logic [LANE_DIVD_W-1:0] w_dividend;
    logic [READ_W-1:0]      w_divisor;
    logic [STEP_W-1:0]      w_steps;
    logic [LANE_Q_W-1:0]    w_q;

    always_comb begin
        w_den       = r_chi - r_clo;
        w_diff      = r_rd - r_clo;
        w_eff_hi    = i_ctl.cal_clear ? '0 : r_chi;
        w_eff_lo    = i_ctl.cal_clear ? READ_W'(i_ctl.max_value) : r_clo;
        n_blo       = (i_ctl.burst_first || r_rd < r_blo) ? r_rd : r_blo;
        n_bhi       = (i_ctl.burst_first || r_rd > r_bhi) ? r_rd : r_bhi;
        w_div_start = i_ctl.avg_start | i_ctl.map_start;
        if (i_ctl.avg_start) begin
            w_dividend = LANE_DIVD_W'(r_sum) + LANE_DIVD_W'(i_ctl.samples >> 1);
            w_divisor  = READ_W'(i_ctl.samples);
            w_steps    = STEP_W'(AVG_STEPS);
        end else begin
            w_dividend = LANE_DIVD_W'(w_diff) * LANE_DIVD_W'(SCALE);
            w_divisor  = w_den;
            w_steps    = STEP_W'(MAP_STEPS);
        end
    end

    lsp_div #(
        .DW (LANE_DIVD_W),
        .VW (READ_W),
        .QW (LANE_Q_W),
        .SW (STEP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_steps    (w_steps),
        .o_quotient (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_chi <= '0;
            r_clo <= READ_W'(MAX_VALUE_RST);
            r_map <= MAP_ZERO;
        end else begin
            if (i_ctl.avg_start) begin
                r_sum <= '0;
            end else if (i_ctl.accum) begin
                r_sum <= r_sum + SUM_W'(i_sample);
            end
            if (i_ctl.map_start) begin
                if (w_den == '0 || r_rd <= r_clo) begin
                    r_map <= MAP_ZERO;
                end else if (w_diff >= w_den) begin
                    r_map <= MAP_FULL;
                end else begin
                    r_map <= MAP_DIV;
                end
            end
            if (i_ctl.burst_update && i_active) begin
                if (i_ctl.burst_end) begin
                    r_chi <= (n_blo > w_eff_hi) ? n_blo : w_eff_hi;
                    r_clo <= (n_bhi < w_eff_lo) ? n_bhi : w_eff_lo;
                end else begin
                    r_chi <= w_eff_hi;
                    r_clo <= w_eff_lo;
                end
            end else if (i_ctl.cal_clear) begin
                r_chi <= '0;
                r_clo <= READ_W'(i_ctl.max_value);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_load) begin
            r_rd <= w_q;
        end
        if (i_ctl.burst_update && i_active) begin
            r_blo <= n_blo;
            r_bhi <= n_bhi;
        end
    end

    always_comb begin
        case (r_map)
            MAP_ZERO: o_value = '0;
            MAP_FULL: o_value = VAL_W'(SCALE);
            MAP_DIV:  o_value = w_q[VAL_W-1:0];
            default:  o_value = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/lsp_merge.sv
// Merge stage: weighted sum over lanes, position divide, lost-line edge.
`default_nettype none
module lsp_merge import lsp_pkg::*; #(
    parameter int SENSORS = SENSORS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [$clog2(SENSORS+1)-1:0]     i_count,
    input  wire logic [VAL_W-1:0]                 i_values [SENSORS],
    output logic                                  o_done,
    output logic      [POS_W-1:0]                 o_position,
    output logic                                  o_seen
);
    localparam int NW    = $clog2(SENSORS + 1);
    localparam int IDX_W = $clog2(SENSORS);
    localparam int WGT_W = $clog2(SCALE * (SENSORS - 1) + 1);
    localparam int WT_W  = $clog2(SCALE * SCALE * SENSORS * (SENSORS - 1) / 2 + 1);
    localparam int TOT_W = $clog2(SCALE * SENSORS + 1);
    localparam int QS_W  = $clog2(WGT_W + 1);
    localparam int CMP_W = (WGT_W > POS_W) ? WGT_W : POS_W;

    typedef enum logic [2:0] {M_IDLE, M_ACC, M_FLUSH, M_DIV, M_DONE} t_mstate;

    t_mstate          r_state;
    logic [IDX_W-1:0] r_idx;
    logic [WGT_W-1:0] r_wt;
    logic [WT_W-1:0]  r_prod;
    logic [WT_W-1:0]  r_weighted;
    logic [TOT_W-1:0] r_total;
    logic             r_seen;
    logic [QS_W-1:0]  r_cnt;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_last;

    logic [VAL_W-1:0] w_v;
    logic             w_keep;
    logic [WGT_W-1:0] w_span;
    logic [WGT_W-1:0] w_edge;
    logic             w_div_start;
    logic [WGT_W-1:0] w_q;

    always_comb begin
        w_v         = i_values[r_idx];
        w_keep      = w_v > VAL_W'(NOISE_LEVEL);
        w_span      = WGT_W'(i_count - NW'(1)) * WGT_W'(SCALE);
        w_edge      = (CMP_W'(r_last) < CMP_W'(w_span >> 1)) ? '0 : w_span;
        w_div_start = (r_state == M_FLUSH) && r_seen;
    end

    lsp_div #(
        .DW (WT_W),
        .VW (TOT_W),
        .QW (WGT_W),
        .SW (QS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_weighted + r_prod),
        .i_divisor  (r_total),
        .i_steps    (QS_W'(WGT_W)),
        .o_quotient (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_last  <= '0;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_idx      <= '0;
                        r_wt       <= '0;
                        r_prod     <= '0;
                        r_weighted <= '0;
                        r_total    <= '0;
                        r_seen     <= 1'b0;
                        r_state    <= M_ACC;
                    end
                end
                M_ACC: begin
                    r_prod     <= w_keep ? WT_W'(w_v) * WT_W'(r_wt) : '0;
                    r_weighted <= r_weighted + r_prod;
                    if (w_keep) begin
                        r_total <= r_total + TOT_W'(w_v);
                    end
                    if (w_v > VAL_W'(LINE_LEVEL)) begin
                        r_seen <= 1'b1;
                    end
                    r_wt  <= r_wt + WGT_W'(SCALE);
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == IDX_W'(i_count - NW'(1))) begin
                        r_state <= M_FLUSH;
                    end
                end
                M_FLUSH: begin
                    r_weighted <= r_weighted + r_prod;
                    if (r_seen) begin
                        r_cnt   <= QS_W'(WGT_W);
                        r_state <= M_DIV;
                    end else begin
                        r_pos   <= POS_W'(w_edge);
                        r_state <= M_DONE;
                    end
                end
                M_DIV: begin
                    if (r_cnt == '0) begin
                        r_pos   <= POS_W'(w_q);
                        r_last  <= POS_W'(w_q);
                        r_state <= M_DONE;
                    end else begin
                        r_cnt <= r_cnt - QS_W'(1);
                    end
                end
                M_DONE: begin
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done     = (r_state == M_DONE);
    assign o_position = r_pos;
    assign o_seen     = r_seen;
endmodule
`default_nettype wire

>>> tb/lsp_tb_if.sv
// Interfaces are provided by the RTL; this file holds the scan item and line result types used by the bench.
`timescale 1ns / 100ps
package lsp_tb_pkg;
    import lsp_pkg::*;

    typedef struct packed {
        t_kind                              kind;
        logic [INPUT_LANES-1:0][SAMPLE_W-1:0] samples;
    } t_scan;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             line_seen;
        logic             not_calibrated;
    } t_line_result;
endpackage

>>> tb/lsp_checker.sv
// Checker: watches the channels, predicts line results and compares them.
`timescale 1ns / 100ps
module lsp_checker import lsp_pkg::*; import lsp_tb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lsp_in_if.sink    i_in,
    lsp_out_if.sink   i_out,
    lsp_cfg_if.sink   i_cfg,
    output int        o_errors,
    output int        o_pending
);
    int unsigned sensor_cnt, spsamp, maxv, cal_en;
    int unsigned sums[8], scans, bmin[8], bmax[8], bursts;
    int unsigned cal_hi[8], cal_lo[8], cal_done, last_pos;
    t_line_result expected_lines[$];

    assign o_pending = expected_lines.size();

    task automatic report(input string what, input int unsigned got, input int unsigned exp);
        $display("%0t: %s got %0d expected %0d", $time, what, got, exp);
        o_errors++;
    endtask

    function automatic int unsigned lanes();
        if (sensor_cnt == 0) return 1;
        if (sensor_cnt > 8) return 8;
        return sensor_cnt;
    endfunction

    task automatic clear_cal();
        for (int i = 0; i < 8; i++) begin
            cal_hi[i] = 0;
            cal_lo[i] = maxv;
        end
    endtask

    task automatic predict_scan(input t_scan s);
        int unsigned n, rd[8], lc, den, v, pos;
        longint unsigned wsum, tot;
        bit seen;
        t_line_result r;
        if (s.kind == KIND_CLEAR) begin
            clear_cal();
            return;
        end
        if (s.kind == KIND_NONE) return;
        if (s.kind == KIND_CAL && cal_en == 0) return;
        for (int i = 0; i < 8; i++) sums[i] += s.samples[i];
        scans++;
        n = (spsamp == 0) ? 1 : (spsamp > 64 ? 64 : spsamp);
        if (scans < n) return;
        for (int i = 0; i < 8; i++) begin
            rd[i] = (sums[i] + n / 2) / n;
            sums[i] = 0;
        end
        scans = 0;
        lc = lanes();
        if (s.kind == KIND_CAL) begin
            if (bursts == 0 && cal_done == 0) begin
                clear_cal();
                cal_done = 1;
            end
            for (int i = 0; i < lc; i++) begin
                if (bursts == 0 || rd[i] < bmin[i]) bmin[i] = rd[i];
                if (bursts == 0 || rd[i] > bmax[i]) bmax[i] = rd[i];
            end
            bursts++;
            if (bursts >= 10) begin
                for (int i = 0; i < lc; i++) begin
                    if (bmin[i] > cal_hi[i]) cal_hi[i] = bmin[i];
                    if (bmax[i] < cal_lo[i]) cal_lo[i] = bmax[i];
                end
                bursts = 0;
            end
            return;
        end
        if (cal_done == 0) begin
            r = '{position: '0, line_seen: 1'b0, not_calibrated: 1'b1};
            expected_lines.push_back(r);
            return;
        end
        wsum = 0;
        tot = 0;
        seen = 0;
        for (int i = 0; i < lc; i++) begin
            den = (cal_hi[i] - cal_lo[i]) & 16'hFFFF;
            v = 0;
            if (den != 0 && rd[i] > cal_lo[i]) begin
                v = (rd[i] - cal_lo[i]) * 1000 / den;
                if (v > 1000) v = 1000;
            end
            if (v > 200) seen = 1;
            if (v > 50) begin
                wsum += longint'(v) * (i * 1000);
                tot += v;
            end
        end
        if (!seen) begin
            pos = (last_pos < (lc - 1) * 1000 / 2) ? 0 : (lc - 1) * 1000;
        end else begin
            pos = 32'(wsum / tot);
            last_pos = pos & 13'h1FFF;
        end
        r = '{position: pos[POS_W-1:0], line_seen: seen, not_calibrated: 1'b0};
        expected_lines.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_scan s;
        t_line_result e;
        if (!i_rst_n) begin
            sensor_cnt = 8; spsamp = 4; maxv = 1023; cal_en = 1;
            scans = 0; bursts = 0; cal_done = 0; last_pos = 0;
            for (int i = 0; i < 8; i++) begin
                sums[i] = 0; bmin[i] = 0; bmax[i] = 0;
            end
            clear_cal();
            expected_lines.delete();
            o_errors = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_SENSOR_COUNT: sensor_cnt = i_cfg.data & 4'hF;
                    CFG_SAMPLES:      spsamp = i_cfg.data & 7'h7F;
                    CFG_MAX_VALUE:    maxv = i_cfg.data;
                    CFG_CAL_ENABLE:   cal_en = i_cfg.data & 1;
                    default:          cal_en = cal_en;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                s.kind = t_kind'(i_in.kind);
                s.samples = {i_in.sample_7, i_in.sample_6, i_in.sample_5, i_in.sample_4,
                             i_in.sample_3, i_in.sample_2, i_in.sample_1, i_in.sample_0};
                predict_scan(s);
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_lines.size() == 0) begin
                    report("unexpected result position", i_out.position, 0);
                end else begin
                    e = expected_lines.pop_front();
                    if (i_out.position !== e.position)
                        report("position", i_out.position, e.position);
                    if (i_out.line_seen !== e.line_seen)
                        report("line_seen", i_out.line_seen, e.line_seen);
                    if (i_out.not_calibrated !== e.not_calibrated)
                        report("not_calibrated", i_out.not_calibrated, e.not_calibrated);
                end
            end
        end
    end
endmodule

>>> tb/testbench.sv
// Top of the bench: drives scans and register writes, then gives the verdict.
`timescale 1ns / 100ps
module testbench;
    import lsp_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   burst_left;
    int   stall_phase;

    lsp_in_if  scan_ch ();
    lsp_out_if line_ch ();
    lsp_cfg_if cfg_ch ();

    line_sensor_position_estimator_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(scan_ch.sink), .o_out(line_ch.source), .i_cfg(cfg_ch.sink)
    );

    lsp_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(scan_ch.sink), .i_out(line_ch.sink), .i_cfg(cfg_ch.sink),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        line_ch.ready = 0;
        stall_phase = 0;
        forever begin
            @(posedge i_clk);
            stall_phase++;
            if (stall_phase % 400 < 100) line_ch.ready <= 1;
            else line_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_scan(input t_kind k, input logic [7:0][SAMPLE_W-1:0] s);
        if (burst_left == 0) begin
            scan_ch.valid <= 0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        scan_ch.valid <= 1;
        scan_ch.kind <= k;
        {scan_ch.sample_7, scan_ch.sample_6, scan_ch.sample_5, scan_ch.sample_4,
         scan_ch.sample_3, scan_ch.sample_2, scan_ch.sample_1, scan_ch.sample_0} <= s;
        @(posedge i_clk);
        while (!scan_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [7:0][SAMPLE_W-1:0] rand_samples();
        logic [7:0][SAMPLE_W-1:0] s;
        for (int i = 0; i < 8; i++) s[i] = SAMPLE_W'($urandom_range(0, 1023));
        return s;
    endfunction

    function automatic logic [7:0][SAMPLE_W-1:0] line_samples();
        logic [7:0][SAMPLE_W-1:0] s;
        int c;
        c = $urandom_range(0, 8);
        for (int i = 0; i < 8; i++) begin
            s[i] = (i == c || i == c + 1) ? SAMPLE_W'($urandom_range(700, 1023)) :
                                            SAMPLE_W'($urandom_range(0, 300));
        end
        return s;
    endfunction

    task automatic cal_burst(input int unsigned sps);
        logic [7:0][SAMPLE_W-1:0] s;
        for (int r = 0; r < 10 * sps; r++) begin
            s = ($urandom_range(0, 1)) ? {8{10'd1000}} : {8{10'd20}};
            if ($urandom_range(0, 3) == 0) s = rand_samples();
            send_scan(KIND_CAL, s);
        end
    endtask

    initial begin
        int unsigned sps;
        i_rst_n = 0;
        burst_left = 0;
        scan_ch.valid = 0;
        scan_ch.kind = KIND_LINE;
        {scan_ch.sample_7, scan_ch.sample_6, scan_ch.sample_5, scan_ch.sample_4,
         scan_ch.sample_3, scan_ch.sample_2, scan_ch.sample_1, scan_ch.sample_0} = '0;
        cfg_ch.valid = 0;
        cfg_ch.index = CFG_SENSOR_COUNT;
        cfg_ch.data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_reg(CFG_SAMPLES, 1);
        send_scan(KIND_LINE, {8{10'd1023}});
        send_scan(KIND_NONE, '0);
        send_scan(KIND_CAL, {8{10'd0}});
        send_scan(KIND_CLEAR, {8{10'd1023}});
        for (int r = 0; r < 5; r++) send_scan(KIND_CAL, {8{10'd1023}});
        for (int r = 0; r < 5; r++) send_scan(KIND_CAL, {8{10'd0}});
        send_scan(KIND_LINE, {10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0});
        send_scan(KIND_LINE, '0);
        send_scan(KIND_LINE, {8{10'd1023}});
        send_scan(KIND_LINE, {10'd1023, {7{10'd0}}});
        send_scan(KIND_LINE, '0);
        send_scan(KIND_CLEAR, '0);
        send_scan(KIND_LINE, rand_samples());
        scan_ch.valid <= 0;
        burst_left = 0;
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: sps = 1;
                1: sps = 64;
                2: sps = 0;
                3: sps = 2;
                4: sps = 100;
                default: sps = $urandom_range(1, 4);
            endcase
            write_reg(CFG_SAMPLES, sps);
            write_reg(CFG_SENSOR_COUNT, (ph == 0) ? 1 : (ph == 1) ? 8 : (ph == 2) ? 0 :
                      (ph == 3) ? 15 : $urandom_range(2, 8));
            write_reg(CFG_MAX_VALUE, (ph == 2) ? 0 : (ph % 2) ? 1023 : $urandom_range(0, 1023));
            write_reg(CFG_CAL_ENABLE, (ph == 5) ? 0 : 1);
            if (sps == 0) sps = 1;
            if (sps > 64) sps = 64;
            if (sps == 64) begin
                for (int r = 0; r < 64; r++) send_scan(KIND_LINE, line_samples());
            end else begin
                if ($urandom_range(0, 1)) send_scan(KIND_CLEAR, rand_samples());
                cal_burst(sps);
                for (int r = 0; r < 30; r++) begin
                    case ($urandom_range(0, 19))
                        0: send_scan(KIND_NONE, rand_samples());
                        1: send_scan(KIND_CLEAR, rand_samples());
                        2: send_scan(KIND_LINE, rand_samples());
                        default: send_scan(KIND_LINE, line_samples());
                    endcase
                end
            end
            scan_ch.valid <= 0;
            burst_left = 0;
            wait_idle();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/lsp_pkg.sv
rtl/lsp_in_if.sv
rtl/lsp_out_if.sv
rtl/lsp_cfg_if.sv
rtl/lsp_div.sv
rtl/lsp_lane.sv
rtl/lsp_merge.sv
rtl/line_sensor_position_estimator_unit.sv
tb/lsp_tb_if.sv
tb/lsp_checker.sv
tb/testbench.sv
